[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TF_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("tf256 assertion failed");

// Implication with a fixed delay in cycles.
`define TF_ASSERT_DLY(label, clk, rst_n, a, n, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##n (c)) \
        else $error("tf256 assertion failed");

`endif

[design/tf256_pkg.sv]
`timescale 1ns / 1ps

package tf256_pkg;

    localparam int                 NUM_ROUNDS   = 72;
    localparam int                 NUM_INJECTS  = 19;
    localparam int                 NUM_CELLS    = NUM_ROUNDS + NUM_INJECTS;
    localparam logic [63:0]        PARITY_RESET = 64'h1BD11BDAA9FC1A22;
    localparam logic               FUNC_ENC     = 1'b0;
    localparam logic               FUNC_DEC     = 1'b1;

    typedef struct packed {
        logic        func;
        logic        feed_forward;
        logic [63:0] block_word0;
        logic [63:0] block_word1;
        logic [63:0] block_word2;
        logic [63:0] block_word3;
        logic [63:0] key_word0;
        logic [63:0] key_word1;
        logic [63:0] key_word2;
        logic [63:0] key_word3;
        logic [63:0] tweak_word0;
        logic [63:0] tweak_word1;
    } tf256_in_t;

    typedef struct packed {
        logic [63:0] out_word0;
        logic [63:0] out_word1;
        logic [63:0] out_word2;
        logic [63:0] out_word3;
    } tf256_out_t;

    // Everything a block carries down the chain.
    typedef struct packed {
        logic             func;
        logic             feed_forward;
        logic [3:0][63:0] b;
        logic [4:0][63:0] k;
        logic [2:0][63:0] t;
        logic [3:0][63:0] orig;
    } lane_t;

    function automatic logic [5:0] rot_amt(input int d, input int j);
        logic [5:0] r0;
        logic [5:0] r1;
        case (d % 8)
            0: begin r0 = 6'd14; r1 = 6'd16; end
            1: begin r0 = 6'd52; r1 = 6'd57; end
            2: begin r0 = 6'd23; r1 = 6'd40; end
            3: begin r0 = 6'd5;  r1 = 6'd37; end
            4: begin r0 = 6'd25; r1 = 6'd33; end
            5: begin r0 = 6'd46; r1 = 6'd12; end
            6: begin r0 = 6'd58; r1 = 6'd22; end
            default: begin r0 = 6'd32; r1 = 6'd32; end
        endcase
        return (j == 0) ? r0 : r1;
    endfunction

    function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] n);
        return (x << n) | (x >> (7'd64 - {1'b0, n}));
    endfunction

    function automatic logic [63:0] rotr64(input logic [63:0] x, input logic [5:0] n);
        return (x >> n) | (x << (7'd64 - {1'b0, n}));
    endfunction

endpackage

[design/tf256_round_cell.sv]
`timescale 1ns / 1ps

// One mix round; ENC_D is the round number when encrypting, DEC_D when decrypting.
module tf256_round_cell #(
    parameter int ENC_D = 0,
    parameter int DEC_D = 71
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  tf256_pkg::lane_t in_lane,
    output logic             out_valid,
    output tf256_pkg::lane_t out_lane
);

    localparam logic [5:0] ER0 = tf256_pkg::rot_amt(ENC_D, 0);
    localparam logic [5:0] ER1 = tf256_pkg::rot_amt(ENC_D, 1);
    localparam logic [5:0] DR0 = tf256_pkg::rot_amt(DEC_D, 0);
    localparam logic [5:0] DR1 = tf256_pkg::rot_amt(DEC_D, 1);
    // partner of word 0 and of word 2
    localparam int EY0 = (ENC_D % 2 == 0) ? 1 : 3;
    localparam int EY1 = (ENC_D % 2 == 0) ? 3 : 1;
    localparam int DY0 = (DEC_D % 2 == 0) ? 1 : 3;
    localparam int DY1 = (DEC_D % 2 == 0) ? 3 : 1;

    logic             valid_reg;
    tf256_pkg::lane_t lane_reg;
    tf256_pkg::lane_t lane_next;
    logic [3:0][63:0] enc_b;
    logic [3:0][63:0] dec_b;

    always_comb
    begin
        enc_b      = in_lane.b;
        enc_b[0]   = in_lane.b[0] + in_lane.b[EY0];
        enc_b[2]   = in_lane.b[2] + in_lane.b[EY1];
        enc_b[EY0] = tf256_pkg::rotl64(in_lane.b[EY0], ER0) ^ enc_b[0];
        enc_b[EY1] = tf256_pkg::rotl64(in_lane.b[EY1], ER1) ^ enc_b[2];

        dec_b      = in_lane.b;
        dec_b[DY0] = tf256_pkg::rotr64(in_lane.b[DY0] ^ in_lane.b[0], DR0);
        dec_b[DY1] = tf256_pkg::rotr64(in_lane.b[DY1] ^ in_lane.b[2], DR1);
        dec_b[0]   = in_lane.b[0] - dec_b[DY0];
        dec_b[2]   = in_lane.b[2] - dec_b[DY1];

        lane_next   = in_lane;
        lane_next.b = (in_lane.func == tf256_pkg::FUNC_DEC) ? dec_b : enc_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;

endmodule

[design/tf256_inject_cell.sv]
`timescale 1ns / 1ps

// Subkey add (encrypt) or subtract (decrypt); ENC_S / DEC_S is the subkey number.
module tf256_inject_cell #(
    parameter int ENC_S = 0,
    parameter int DEC_S = 18
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  tf256_pkg::lane_t in_lane,
    output logic             out_valid,
    output tf256_pkg::lane_t out_lane
);

    localparam int EK0 = ENC_S % 5;
    localparam int EK1 = (ENC_S + 1) % 5;
    localparam int EK2 = (ENC_S + 2) % 5;
    localparam int EK3 = (ENC_S + 3) % 5;
    localparam int ET0 = ENC_S % 3;
    localparam int ET1 = (ENC_S + 1) % 3;
    localparam int DK0 = DEC_S % 5;
    localparam int DK1 = (DEC_S + 1) % 5;
    localparam int DK2 = (DEC_S + 2) % 5;
    localparam int DK3 = (DEC_S + 3) % 5;
    localparam int DT0 = DEC_S % 3;
    localparam int DT1 = (DEC_S + 1) % 3;
    localparam logic [63:0] ES = 64'(ENC_S);
    localparam logic [63:0] DS = 64'(DEC_S);

    logic             valid_reg;
    tf256_pkg::lane_t lane_reg;
    tf256_pkg::lane_t lane_next;
    logic [3:0][63:0] sk;
    logic             dec;

    always_comb
    begin
        dec = (in_lane.func == tf256_pkg::FUNC_DEC);
        sk[0] = dec ? in_lane.k[DK0] : in_lane.k[EK0];
        sk[1] = dec ? (in_lane.k[DK1] + in_lane.t[DT0]) : (in_lane.k[EK1] + in_lane.t[ET0]);
        sk[2] = dec ? (in_lane.k[DK2] + in_lane.t[DT1]) : (in_lane.k[EK2] + in_lane.t[ET1]);
        sk[3] = dec ? (in_lane.k[DK3] + DS) : (in_lane.k[EK3] + ES);
        lane_next = in_lane;
        for (int j = 0; j < 4; j++)
        begin
            lane_next.b[j] = dec ? (in_lane.b[j] - sk[j]) : (in_lane.b[j] + sk[j]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;

endmodule

[design/threefish256_block_cipher.sv]
`timescale 1ns / 1ps

// Channel   Handshake         Payload
// input     start & !busy     blk_in  (tf256_in_t)
// result    done (one cycle)  blk_out (tf256_out_t)
// config    cfg_we            cfg_wdata (key parity)
//
// Fully pipelined: one block per cycle, every cycle, busy is always low.
// The pipeline is the input register, 91 cells (72 rounds, 19 subkey
// injections) and the output register with feed-forward.
// Reset clears the valid bits along the chain and loads the default parity.
// The receiver cannot stall; each result is shown for exactly one cycle.

`include "assert_macros.svh"

module threefish256_block_cipher (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  tf256_pkg::tf256_in_t  blk_in,
    output logic                  done,
    output tf256_pkg::tf256_out_t blk_out,
    input  logic                  cfg_we,
    input  logic [63:0]           cfg_wdata
);

    localparam int NC = tf256_pkg::NUM_CELLS;

    logic [63:0]           parity_reg;
    logic                  valid_chain [0:NC];
    tf256_pkg::lane_t      lane_chain  [0:NC];
    logic                  in_valid_reg;
    tf256_pkg::lane_t      in_lane_reg;
    tf256_pkg::lane_t      in_lane_next;
    logic                  done_reg;
    tf256_pkg::tf256_out_t out_reg;
    tf256_pkg::tf256_out_t out_next;
    logic                  accept;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg <= tf256_pkg::PARITY_RESET;
        end
        else if (cfg_we)
        begin
            parity_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        in_lane_next.func         = blk_in.func;
        in_lane_next.feed_forward = blk_in.feed_forward;
        in_lane_next.b    = {blk_in.block_word3, blk_in.block_word2,
                             blk_in.block_word1, blk_in.block_word0};
        in_lane_next.orig = in_lane_next.b;
        in_lane_next.k[0] = blk_in.key_word0;
        in_lane_next.k[1] = blk_in.key_word1;
        in_lane_next.k[2] = blk_in.key_word2;
        in_lane_next.k[3] = blk_in.key_word3;
        in_lane_next.k[4] = parity_reg ^ blk_in.key_word0 ^ blk_in.key_word1
                          ^ blk_in.key_word2 ^ blk_in.key_word3;
        in_lane_next.t[0] = blk_in.tweak_word0;
        in_lane_next.t[1] = blk_in.tweak_word1;
        in_lane_next.t[2] = blk_in.tweak_word0 ^ blk_in.tweak_word1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        in_lane_reg <= in_lane_next;
    end

    assign valid_chain[0] = in_valid_reg;
    assign lane_chain[0]  = in_lane_reg;

    // Cell i: every fifth one injects a subkey, the four between run rounds.
    // Decrypt walks the same slots in mirrored order.
    genvar i;
    generate
        for (i = 0; i < NC; i++)
        begin : g_cell
            localparam int GRP = i / 5;
            localparam int POS = i % 5;
            if (POS == 0)
            begin : g_inj
                tf256_inject_cell #(
                    .ENC_S(GRP),
                    .DEC_S(tf256_pkg::NUM_INJECTS - 1 - GRP)
                ) u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .in_valid (valid_chain[i]),
                    .in_lane  (lane_chain[i]),
                    .out_valid(valid_chain[i+1]),
                    .out_lane (lane_chain[i+1])
                );
            end
            else
            begin : g_rnd
                tf256_round_cell #(
                    .ENC_D(4 * GRP + POS - 1),
                    .DEC_D(tf256_pkg::NUM_ROUNDS - 1 - (4 * GRP + POS - 1))
                ) u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .in_valid (valid_chain[i]),
                    .in_lane  (lane_chain[i]),
                    .out_valid(valid_chain[i+1]),
                    .out_lane (lane_chain[i+1])
                );
            end
        end
    endgenerate

    always_comb
    begin
        logic [3:0][63:0] res;
        res = lane_chain[NC].b;
        if (lane_chain[NC].func == tf256_pkg::FUNC_ENC && lane_chain[NC].feed_forward)
        begin
            res = res ^ lane_chain[NC].orig;
        end
        out_next.out_word0 = res[0];
        out_next.out_word1 = res[1];
        out_next.out_word2 = res[2];
        out_next.out_word3 = res[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_chain[NC];
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign done    = done_reg;
    assign blk_out = out_reg;

    `TF_ASSERT_DLY(a_latency, clk, rst_n, accept, 93, done)
    `TF_ASSERT_IMP(a_no_phantom, clk, rst_n, done, $past(accept, 93))
    `TF_ASSERT_IMP(a_tail_valid, clk, rst_n, done, $past(valid_chain[NC]))

endmodule

[tb/sv/threefish256_block_cipher_tb.sv]
`timescale 1ns / 1ps

module threefish256_block_cipher_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 100;
    localparam int RAND_PER_PHASE = 290;
    localparam int NUM_PHASES = 5;
    localparam int ROT_AMT [16] = '{14, 16, 52, 57, 23, 40, 5, 37,
                                    25, 33, 46, 12, 58, 22, 32, 32};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    tf256_pkg::tf256_in_t  blk_in = '0;
    logic                  done;
    tf256_pkg::tf256_out_t blk_out;
    logic                  cfg_we = 1'b0;
    logic [63:0]           cfg_wdata = '0;

    threefish256_block_cipher uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .blk_in(blk_in),
        .done(done), .blk_out(blk_out), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    tf256_pkg::tf256_out_t expected_blocks[$];
    logic [63:0] parity_shadow = tf256_pkg::PARITY_RESET;
    int          mismatches = 0;
    int          cycles = 0;

    function automatic logic [63:0] rol(input logic [63:0] x, input int n);
        return (n == 0) ? x : ((x << n) | (x >> (64 - n)));
    endfunction

    function automatic logic [63:0] ror(input logic [63:0] x, input int n);
        return (n == 0) ? x : ((x >> n) | (x << (64 - n)));
    endfunction

    // word j of subkey s
    function automatic logic [63:0] subkey_word(input logic [4:0][63:0] k,
                                                input logic [2:0][63:0] t,
                                                input int s, input int j);
        logic [63:0] w;
        w = k[(s + j) % 5];
        if (j == 1) w = w + t[s % 3];
        if (j == 2) w = w + t[(s + 1) % 3];
        if (j == 3) w = w + 64'(s);
        return w;
    endfunction

    function automatic tf256_pkg::tf256_out_t cipher_block(input tf256_pkg::tf256_in_t x,
                                                           input logic [63:0] parity);
        logic [3:0][63:0] b;
        logic [4:0][63:0] k;
        logic [2:0][63:0] t;
        int px, py;
        tf256_pkg::tf256_out_t r;
        b = {x.block_word3, x.block_word2, x.block_word1, x.block_word0};
        k[0] = x.key_word0; k[1] = x.key_word1; k[2] = x.key_word2; k[3] = x.key_word3;
        k[4] = parity ^ k[0] ^ k[1] ^ k[2] ^ k[3];
        t[0] = x.tweak_word0; t[1] = x.tweak_word1; t[2] = t[0] ^ t[1];
        if (x.func == tf256_pkg::FUNC_ENC)
        begin
            for (int d = 0; d < tf256_pkg::NUM_ROUNDS; d++)
            begin
                if (d % 4 == 0)
                    for (int j = 0; j < 4; j++) b[j] = b[j] + subkey_word(k, t, d / 4, j);
                for (int j = 0; j < 2; j++)
                begin
                    px = 2 * j;
                    py = (d % 2 == 0) ? 2 * j + 1 : 3 - 2 * j;
                    b[px] = b[px] + b[py];
                    b[py] = rol(b[py], ROT_AMT[2 * (d % 8) + j]) ^ b[px];
                end
            end
            for (int j = 0; j < 4; j++)
                b[j] = b[j] + subkey_word(k, t, tf256_pkg::NUM_INJECTS - 1, j);
            if (x.feed_forward)
                b = b ^ {x.block_word3, x.block_word2, x.block_word1, x.block_word0};
        end
        else
        begin
            for (int j = 0; j < 4; j++)
                b[j] = b[j] - subkey_word(k, t, tf256_pkg::NUM_INJECTS - 1, j);
            for (int d = tf256_pkg::NUM_ROUNDS - 1; d >= 0; d--)
            begin
                for (int j = 0; j < 2; j++)
                begin
                    px = 2 * j;
                    py = (d % 2 == 0) ? 2 * j + 1 : 3 - 2 * j;
                    b[py] = ror(b[py] ^ b[px], ROT_AMT[2 * (d % 8) + j]);
                    b[px] = b[px] - b[py];
                end
                if (d % 4 == 0)
                    for (int j = 0; j < 4; j++) b[j] = b[j] - subkey_word(k, t, d / 4, j);
            end
        end
        r.out_word0 = b[0]; r.out_word1 = b[1]; r.out_word2 = b[2]; r.out_word3 = b[3];
        return r;
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 64'(1) << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic tf256_pkg::tf256_in_t rand_item();
        tf256_pkg::tf256_in_t x;
        x.func = 1'($urandom);
        x.feed_forward = 1'($urandom);
        x.block_word0 = rand_word(); x.block_word1 = rand_word();
        x.block_word2 = rand_word(); x.block_word3 = rand_word();
        x.key_word0 = rand_word(); x.key_word1 = rand_word();
        x.key_word2 = rand_word(); x.key_word3 = rand_word();
        x.tweak_word0 = rand_word(); x.tweak_word1 = rand_word();
        return x;
    endfunction

    // start stays high between back-to-back transfers; lowered only for idle bursts
    task automatic send_block(input tf256_pkg::tf256_in_t x, input bit may_idle);
        int gap;
        if (may_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 12);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        blk_in <= x;
        do @(posedge clk); while (busy);
        expected_blocks.push_back(cipher_block(x, parity_shadow));
    endtask

    task automatic write_parity(input logic [63:0] value);
        start <= 1'b0;
        wait (expected_blocks.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        parity_shadow = value;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_blocks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", blk_out);
            end
            else
            begin
                tf256_pkg::tf256_out_t e;
                e = expected_blocks.pop_front();
                if (blk_out.out_word0 !== e.out_word0 || blk_out.out_word1 !== e.out_word1 ||
                    blk_out.out_word2 !== e.out_word2 || blk_out.out_word3 !== e.out_word3)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", e, blk_out);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    tf256_pkg::tf256_in_t directed_table[$];

    initial
    begin
        tf256_pkg::tf256_in_t x;
        logic [63:0] phase_parity [NUM_PHASES];
        phase_parity = '{tf256_pkg::PARITY_RESET, 64'h0, '1, {$urandom, $urandom},
                         tf256_pkg::PARITY_RESET};

        // all-zero and all-one blocks, both directions, feed-forward on and off
        x = '0;                                   directed_table.push_back(x);
        x.feed_forward = 1'b1;                    directed_table.push_back(x);
        x = '1; x.func = tf256_pkg::FUNC_ENC; x.feed_forward = 1'b0;
        directed_table.push_back(x);
        x.feed_forward = 1'b1;                    directed_table.push_back(x);
        x = '1;                                   directed_table.push_back(x);
        x = '0; x.func = tf256_pkg::FUNC_DEC;     directed_table.push_back(x);
        // decrypt with feed-forward set: flag has no effect
        x.feed_forward = 1'b1;                    directed_table.push_back(x);
        // equal tweak words make the third tweak word zero
        x = rand_item(); x.tweak_word1 = x.tweak_word0; directed_table.push_back(x);
        // key words that cancel the parity: fifth key word zero
        x = rand_item();
        x.key_word3 = tf256_pkg::PARITY_RESET ^ x.key_word0 ^ x.key_word1 ^ x.key_word2;
        directed_table.push_back(x);
        x = '0; x.block_word0 = '1; x.key_word3 = '1; x.tweak_word1 = '1;
        directed_table.push_back(x);
        x.func = tf256_pkg::FUNC_DEC;             directed_table.push_back(x);
        x = '0; x.block_word3 = 64'h8000_0000_0000_0000; x.key_word0 = 64'h1;
        x.tweak_word0 = 64'h8000_0000_0000_0000; directed_table.push_back(x);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p > 0) write_parity(phase_parity[p]);
            if (p == 0)
                foreach (directed_table[i]) send_block(directed_table[i], 1'b1);
            for (int i = 0; i < RAND_PER_PHASE; i++)
                send_block(rand_item(), p != NUM_PHASES - 1);
        end
        start <= 1'b0;

        wait (expected_blocks.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_blocks.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[threefish256_block_cipher.f]
+incdir+design
design/tf256_pkg.sv
design/tf256_round_cell.sv
design/tf256_inject_cell.sv
design/threefish256_block_cipher.sv
tb/sv/threefish256_block_cipher_tb.sv
